@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file; sample on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/rsmp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmp_pkg
// Types and constants of the polyphase rational resampler.
// ----------------------------------------------------------------------------
package rsmp_pkg;

    localparam logic [1:0] CFG_INTERP = 2'd0;
    localparam logic [1:0] CFG_DECIM  = 2'd1;
    localparam logic [1:0] CFG_TAPS   = 2'd2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_COEF = 1'b1;

    localparam int RESULT_CAP = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MOD,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
    } sample_t;

    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctrl_t;

endpackage

@@ rtl/rsmp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmp_cell
// One delay line cell: shifts from the previous cell on a push, takes the
// next cell's sample while the line rotates past the MAC.
// ----------------------------------------------------------------------------
module rsmp_cell
    import rsmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  sample_t    from_prev,
    input  sample_t    from_next,
    output sample_t    value
);

    sample_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (ctrl.shift)
        begin
            value_reg <= from_prev;
        end
        else if (ctrl.rotate)
        begin
            value_reg <= from_next;
        end
    end

    assign value = value_reg;

endmodule

@@ rtl/rsmp_mac.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmp_mac
// Complex-by-real multiply accumulate with round half up and saturation.
// ----------------------------------------------------------------------------
module rsmp_mac
    import rsmp_pkg::*;
#(
    parameter int ACC_W = 38
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               in_en,
    input  logic signed [15:0] coef,
    input  sample_t            samp,
    output logic signed [15:0] res_i,
    output logic signed [15:0] res_q
);

    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] MINV = ~MAXV;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(16384);

    logic                      en_reg;
    logic signed [31:0]        prod_i_reg;
    logic signed [31:0]        prod_q_reg;
    logic signed [ACC_W-1:0]   acc_i_reg;
    logic signed [ACC_W-1:0]   acc_q_reg;
    logic signed [ACC_W-1:0]   rnd_i;
    logic signed [ACC_W-1:0]   rnd_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else
        begin
            en_reg <= in_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_i_reg <= coef * samp.i;
        prod_q_reg <= coef * samp.q;
        if (clear)
        begin
            acc_i_reg <= '0;
            acc_q_reg <= '0;
        end
        else if (en_reg)
        begin
            acc_i_reg <= acc_i_reg + ACC_W'(prod_i_reg);
            acc_q_reg <= acc_q_reg + ACC_W'(prod_q_reg);
        end
    end

    assign rnd_i = (acc_i_reg + HALF) >>> 15;
    assign rnd_q = (acc_q_reg + HALF) >>> 15;

    always_comb
    begin
        if (rnd_i > MAXV)
            res_i = 16'sh7fff;
        else if (rnd_i < MINV)
            res_i = -16'sh8000;
        else
            res_i = rnd_i[15:0];
        if (rnd_q > MAXV)
            res_q = 16'sh7fff;
        else if (rnd_q < MINV)
            res_q = -16'sh8000;
        else
            res_q = rnd_q[15:0];
    end

endmodule

@@ rtl/polyphase_rational_resampler.sv @@
`timescale 1ns / 1ps
// Sequence: a push goes from ST_IDLE to ST_START; each output then passes ST_MOD (which
// also wraps a phase at or above MAX_PHASES), ST_MAC, ST_DRAIN and ST_EMIT, which holds on an output stall.
// Throughput: one MAC tap per cycle as the delay line rotates past one shared MAC unit.
// A coefficient write leaves the block idle. Reset clears delay line, phase and control;
// registers reset to p=1, q=1, taps=32; the coefficient memory is not cleared.
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// Rational p/q resampler of complex Q1.15 samples over a polyphase FIR bank.
// ----------------------------------------------------------------------------
module polyphase_rational_resampler
    import rsmp_pkg::*;
#(
    parameter int TAPS       = 32,
    parameter int MAX_PHASES = 128
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic signed [15:0] sample_i,
    input  logic signed [15:0] sample_q,
    input  logic [11:0]        coef_index,
    input  logic signed [15:0] coef_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_i,
    output logic signed [15:0] out_q,
    output logic               last_of_run
);

    localparam int DEPTH = MAX_PHASES * TAPS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(TAPS + 1);
    localparam int ACC_W = 33 + $clog2(TAPS);

    state_t          state_reg, state_next;
    logic [7:0]      p_reg, q_reg;
    logic [5:0]      taps_reg;
    logic [8:0]      phase_reg, phase_next;
    logic [8:0]      phmod_reg, phmod_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [TW-1:0]   t_reg, t_next;
    logic [6:0]      count_reg, count_next;
    logic            drain_reg, drain_next;
    logic            out_valid_reg, out_valid_next;
    logic signed [15:0] out_i_reg, out_q_reg;
    logic            last_reg;
    logic            load_out;
    logic            last_now;

    logic signed [15:0] mem [DEPTH];
    logic signed [15:0] coef_rd_reg;
    sample_t         samp_reg;
    logic            v1_reg;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [7:0]      ntaps;
    logic [8:0]      nph;
    logic [6:0]      cnt1;
    logic signed [15:0] res_i, res_q;
    logic            mac_clear;

    cell_ctrl_t      cctrl;
    sample_t         cells [TAPS];
    sample_t         new_samp;

    function automatic logic [8:0] settle(input logic [8:0] ph, input logic [7:0] p);
        settle = (ph >= {1'b0, p}) ? ph - {1'b0, p} : 9'd0;
    endfunction

    assign new_samp.i = sample_i;
    assign new_samp.q = sample_q;
    assign cctrl.shift  = (state_reg == ST_IDLE) && in_valid && (mode == MODE_PUSH);
    assign cctrl.rotate = (state_reg == ST_MAC);

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        rsmp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cctrl),
            .from_prev ((k == 0) ? new_samp : cells[(k + TAPS - 1) % TAPS]),
            .from_next (cells[(k + 1) % TAPS]),
            .value     (cells[k])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg    <= 8'd1;
            q_reg    <= 8'd1;
            taps_reg <= 6'd32;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_INTERP: p_reg    <= cfg_data;
                CFG_DECIM:  q_reg    <= cfg_data;
                CFG_TAPS:   taps_reg <= cfg_data[5:0];
                default:    ;
            endcase
        end
    end

    assign mem_we  = (state_reg == ST_IDLE) && in_valid && (mode == MODE_COEF)
                     && (32'(coef_index) < DEPTH);
    assign rd_addr = base_reg + AW'(t_reg);
    assign ntaps   = (32'(taps_reg) > TAPS) ? 8'(TAPS) : 8'(taps_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[AW'(32'(coef_index))] <= coef_value;
        coef_rd_reg <= mem[rd_addr];
        samp_reg    <= cells[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= (state_reg == ST_MAC) && (32'(t_reg) < 32'(ntaps));
    end

    assign mac_clear = (state_reg == ST_MOD);

    rsmp_mac #(.ACC_W(ACC_W)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mac_clear),
        .in_en (v1_reg),
        .coef  (coef_rd_reg),
        .samp  (samp_reg),
        .res_i (res_i),
        .res_q (res_q)
    );

    assign nph      = phase_reg + 9'(q_reg);
    assign cnt1     = count_reg + 7'd1;
    assign last_now = !((nph < {1'b0, p_reg}) && (32'(cnt1) < RESULT_CAP));

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        phmod_next     = phmod_reg;
        base_next      = base_reg;
        t_next         = t_reg;
        count_next     = count_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !out_ready;
        load_out       = 1'b0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (mode == MODE_PUSH))
                    state_next = ST_START;
            end
            ST_START:
            begin
                count_next = '0;
                if (phase_reg < {1'b0, p_reg})
                begin
                    phmod_next = phase_reg;
                    state_next = ST_MOD;
                end
                else
                begin
                    phase_next = settle(phase_reg, p_reg);
                    state_next = ST_IDLE;
                end
            end
            ST_MOD:
            begin
                if (32'(phmod_reg) >= MAX_PHASES)
                    phmod_next = phmod_reg - 9'(MAX_PHASES);
                else
                begin
                    base_next  = AW'(32'(phmod_reg) * TAPS);
                    t_next     = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                t_next = t_reg + TW'(1);
                if (32'(t_reg) == TAPS - 1)
                begin
                    drain_next = 1'b0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                drain_next = 1'b1;
                if (drain_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    count_next     = cnt1;
                    if (last_now)
                    begin
                        phase_next = settle(nph, p_reg);
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        phase_next = nph;
                        phmod_next = nph;
                        state_next = ST_MOD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            phmod_reg     <= '0;
            base_reg      <= '0;
            t_reg         <= '0;
            count_reg     <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            phmod_reg     <= phmod_next;
            base_reg      <= base_next;
            t_reg         <= t_next;
            count_reg     <= count_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_i_reg <= res_i;
            out_q_reg <= res_q;
            last_reg  <= last_now;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_i       = out_i_reg;
    assign out_q       = out_q_reg;
    assign last_of_run = last_reg;

endmodule

@@ rtl/rsmp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsmp_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsmp_checker
    import rsmp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic mode,
    input logic out_valid,
    input logic out_ready
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `ASSERT_NEXT(a_coef_one_cycle, in_valid && in_ready && (mode == MODE_COEF), in_ready)
    `ASSERT_NEXT(a_push_busy, in_valid && in_ready && (mode == MODE_PUSH), !in_ready)
    `ASSERT_IMPL(a_ready_known, 1'b1, !$isunknown(in_ready))

endmodule

bind polyphase_rational_resampler rsmp_checker u_rsmp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .out_valid (out_valid),
    .out_ready (out_ready)
);

@@ bench/resampler_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resampler_checker
// Watches the request and output channels of the resampler, runs a bit-exact
// polyphase model on every accepted push and compares each output in order.
// ----------------------------------------------------------------------------
module resampler_checker
    import rsmp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               mode,
    input  logic signed [15:0] sample_i,
    input  logic signed [15:0] sample_q,
    input  logic [11:0]        coef_index,
    input  logic signed [15:0] coef_value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] out_i,
    input  logic signed [15:0] out_q,
    input  logic               last_of_run,
    output int                 fail_count,
    output int                 pending
);
    localparam int NTAP = 32;
    localparam int NPH  = 128;
    localparam int DEPTH = NTAP * NPH;

    typedef struct packed {
        logic signed [15:0] i;
        logic signed [15:0] q;
        logic               last;
    } resampled_t;

    resampled_t         expected_outputs[$];
    logic signed [15:0] hist_i[NTAP];
    logic signed [15:0] hist_q[NTAP];
    logic signed [15:0] coefs[DEPTH];
    logic [8:0]         phase;
    logic [7:0]         p_reg, q_reg;
    logic [5:0]         taps_reg;

    function automatic logic signed [15:0] round_sat(longint acc);
        longint r;
        r = (acc + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    task automatic resample_push(logic signed [15:0] si, logic signed [15:0] sq);
        int         n, cnt;
        longint     ai, aq, c;
        resampled_t r;
        n = (taps_reg > NTAP) ? NTAP : taps_reg;
        cnt = 0;
        for (int k = NTAP - 1; k > 0; k--)
        begin
            hist_i[k] = hist_i[k - 1];
            hist_q[k] = hist_q[k - 1];
        end
        hist_i[0] = si;
        hist_q[0] = sq;
        while (phase < p_reg && cnt < RESULT_CAP)
        begin
            ai = 0;
            aq = 0;
            for (int t = 0; t < n; t++)
            begin
                c = coefs[((phase % NPH) * NTAP + t) % DEPTH];
                ai += c * hist_i[t];
                aq += c * hist_q[t];
            end
            r.i = round_sat(ai);
            r.q = round_sat(aq);
            r.last = 1'b0;
            expected_outputs.push_back(r);
            cnt++;
            phase = phase + q_reg;
        end
        if (cnt > 0)
            expected_outputs[$].last = 1'b1;
        if (phase >= p_reg) phase = phase - p_reg;
        else phase = '0;
    endtask

    assign pending = expected_outputs.size();

    always @(posedge clk or negedge rst_n)
    begin
        resampled_t e;
        if (!rst_n)
        begin
            expected_outputs.delete();
            for (int k = 0; k < NTAP; k++)
            begin
                hist_i[k] = '0;
                hist_q[k] = '0;
            end
            phase = '0;
            p_reg = 8'd1;
            q_reg = 8'd1;
            taps_reg = 6'd32;
            fail_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outputs.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output i=%0d q=%0d last=%0b",
                                 out_i, out_q, last_of_run);
                end
                else
                begin
                    e = expected_outputs.pop_front();
                    if (e.i !== out_i || e.q !== out_q || e.last !== last_of_run)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch exp i=%0d q=%0d last=%0b got i=%0d q=%0d last=%0b",
                                     e.i, e.q, e.last, out_i, out_q, last_of_run);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                if (mode == MODE_COEF)
                    coefs[coef_index] = coef_value;
                else
                    resample_push(sample_i, sample_q);
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_INTERP: p_reg = cfg_data;
                    CFG_DECIM:  q_reg = cfg_data;
                    CFG_TAPS:   taps_reg = cfg_data[5:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

@@ bench/tb_polyphase_rational_resampler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polyphase_rational_resampler
// Loads coefficient banks, sweeps p, q and tap count over several phases and
// pushes directed and random samples under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_polyphase_rational_resampler;
    import rsmp_pkg::*;

    localparam int  LIMIT = 1000000;
    localparam int  DRAIN = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               mode = MODE_PUSH;
    logic signed [15:0] sample_i = '0;
    logic signed [15:0] sample_q = '0;
    logic [11:0]        coef_index = '0;
    logic signed [15:0] coef_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] out_i;
    logic signed [15:0] out_q;
    logic               last_of_run;
    int                 fail_count;
    int                 pending;
    int                 cycles = 0;
    bit                 calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    polyphase_rational_resampler DUT (.*);

    resampler_checker u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= 10);

    task automatic send(logic m, logic [15:0] si, logic [15:0] sq,
                        logic [11:0] ci, logic [15:0] cv);
        while (!calm && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        sample_i   <= si;
        sample_q   <= sq;
        coef_index <= ci;
        coef_value <= cv;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic push(logic [15:0] si, logic [15:0] sq);
        send(MODE_PUSH, si, sq, 12'($urandom), 16'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // fill the first nt taps of phase ph; some taps get extreme values
    task automatic load_taps(int ph, int nt);
        logic [15:0] v;
        for (int a = 0; a < nt; a++)
        begin
            case ($urandom_range(7))
                0: v = 16'h7fff;
                1: v = 16'h8000;
                2: v = 16'(($urandom_range(1) ? 1 : -1) * $urandom_range(300));
                default: v = 16'($urandom);
            endcase
            send(MODE_COEF, 16'($urandom), 16'($urandom), 12'(ph * 32 + a), v);
        end
    endtask

    task automatic configure(logic [7:0] p, logic [7:0] q, logic [7:0] t);
        set_reg(CFG_INTERP, p);
        set_reg(CFG_DECIM, q);
        set_reg(CFG_TAPS, t);
    endtask

    task automatic random_pushes(int n);
        logic [15:0] si, sq;
        for (int j = 0; j < n; j++)
        begin
            case ($urandom_range(5))
                0: begin si = 16'h7fff; sq = 16'h8000; end
                1: begin si = 16'h8000; sq = 16'h8000; end
                default: begin si = 16'($urandom); sq = 16'($urandom); end
            endcase
            push(si, sq);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 0 full, phases 1..3 short, even phases 4 to 126 first tap only
        load_taps(0, 32);
        for (int ph = 1; ph < 4; ph++)
            load_taps(ph, 8);
        for (int ph = 4; ph < 128; ph += 2)
            load_taps(ph, 1);
        settle();

        // directed: extremes of samples at the reset setting
        push(16'h7fff, 16'h7fff);
        push(16'h8000, 16'h8000);
        push(16'h0000, 16'hffff);
        push(16'h7fff, 16'h8000);
        push(16'h0001, 16'h8000);
        settle();
        // maximum output run of one input: p = 64q
        configure(8'd128, 8'd2, 8'd1);
        push(16'h7fff, 16'h8000);
        push(16'h1234, 16'hedcb);
        settle();
        // too many outputs: p above 64q and q of zero
        configure(8'd130, 8'd2, 8'd1);
        push(16'h8000, 16'h7fff);
        push(16'h4000, 16'hc000);
        settle();
        configure(8'd5, 8'd0, 8'd8);
        push(16'h7fff, 16'h7fff);
        push(16'h0100, 16'h0100);
        settle();
        // zero taps and p of zero
        configure(8'd3, 8'd2, 8'd0);
        push(16'h7fff, 16'h7fff);
        push(16'h7fff, 16'h7fff);
        settle();
        configure(8'd0, 8'd3, 8'd32);
        push(16'h7fff, 16'h7fff);
        settle();
        // tap count above the filter length
        configure(8'd1, 8'd1, 8'd63);
        push(16'h7fff, 16'h8000);
        push(16'h2222, 16'hdddd);
        settle();

        configure(8'd3, 8'd2, 8'd8);
        random_pushes(10);
        settle();
        calm = 1'b1;
        configure(8'd2, 8'd5, 8'd8);
        random_pushes(10);
        settle();
        calm = 1'b0;
        configure(8'd4, 8'd3, 8'd8);
        random_pushes(6);
        settle();
        configure(8'd128, 8'd128, 8'd8);
        random_pushes(2);
        settle();
        // decimating, p=1 q=128
        configure(8'd1, 8'd128, 8'd32);
        push(16'h7fff, 16'h8000);
        push(16'h7fff, 16'h8000);
        settle();
        // phases at or above the phase count wrap
        configure(8'd200, 8'd130, 8'd1);
        random_pushes(6);
        settle();

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
